>>> src/crcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_pkg: shared types and constants of the CRC/parity link error control
// Holds the check width, the configuration register indexes, the job record
// that travels from the front part to the back part, and the queue sizing.
// ----------------------------------------------------------------------------
package crcl_pkg;

  // Width of the CRC remainder and of the receive strip line.
  localparam int CHECK_WIDTH = 15;
  // Bits needed to count strip line entries up to CHECK_WIDTH.
  localparam int FILL_W      = $clog2(CHECK_WIDTH + 1);
  // Bits needed to index one check bit.
  localparam int IDX_W       = $clog2(CHECK_WIDTH);

  // Job queue depth between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_DIRECTION  = 2'd0;
  localparam logic [1:0] REG_CHECK_KIND = 2'd1;
  localparam logic [1:0] REG_GENERATOR  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic                   DIRECTION_RESET  = 1'b0;
  localparam logic                   CHECK_KIND_RESET = 1'b1;
  localparam logic [CHECK_WIDTH-1:0] GENERATOR_RESET  = CHECK_WIDTH'(2429);

  // Direction and check kind codes.
  localparam logic DIR_TRANSMIT = 1'b0;
  localparam logic DIR_RECEIVE  = 1'b1;
  localparam logic KIND_PARITY  = 1'b0;
  localparam logic KIND_CRC     = 1'b1;

  // What follows the optional data bit of a job.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_PARITY,
    TAIL_CRC,
    TAIL_VERDICT
  } tail_kind_t;

  // Configuration as seen by the front part.
  typedef struct packed {
    logic                   direction;
    logic                   check_kind;
    logic [CHECK_WIDTH-1:0] generator;
  } cfg_t;

  // One job: an optional data bit and an optional tail of check or verdict items.
  typedef struct packed {
    logic                   has_bit;
    logic                   bit_val;
    tail_kind_t             tail;
    logic [CHECK_WIDTH-1:0] data;
  } job_t;

endpackage

>>> src/crc_parity_link_error_control_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_parity_link_error_control_unit: bit-serial CRC-15 / parity link unit
// Top level: configuration registers, front part, job queue and back part.
// ----------------------------------------------------------------------------
// The unit takes one frame bit per clock cycle while the job queue is not
// full and gives one result item per clock cycle while out_ready is high.
// In transmit mode each bit comes out again and the frame end adds one
// parity bit or fifteen CRC bits; in receive mode each bit gives at most
// one output item and the frame end adds one verdict item. The front part
// updates the check state for each accepted bit; the back part emits the
// items from a four-entry job queue, and the input stalls only while that
// queue is full. There is no clearing pass after reset. Configuration is
// written through cfg_we, cfg_index and cfg_wdata while no frame is in flight.
// ----------------------------------------------------------------------------
module crc_parity_link_error_control_unit
  import crcl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CHECK_WIDTH-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_data_bit,
  input  logic                   in_frame_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_bit,
  output logic                   out_is_verdict,
  output logic                   out_error_found,
  output logic                   out_run_end
);

  logic                   direction_r, direction_nxt;
  logic                   check_kind_r, check_kind_nxt;
  logic [CHECK_WIDTH-1:0] generator_r, generator_nxt;

  cfg_t cfg;
  job_t push_job;
  job_t head_job;
  logic q_push, q_pop, q_full, q_empty;

  // Configuration register writes; an unused index is ignored.
  always_comb begin
    direction_nxt  = direction_r;
    check_kind_nxt = check_kind_r;
    generator_nxt  = generator_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION:  direction_nxt  = cfg_wdata[0];
        REG_CHECK_KIND: check_kind_nxt = cfg_wdata[0];
        REG_GENERATOR:  generator_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= DIRECTION_RESET;
      check_kind_r <= CHECK_KIND_RESET;
      generator_r  <= GENERATOR_RESET;
    end else begin
      direction_r  <= direction_nxt;
      check_kind_r <= check_kind_nxt;
      generator_r  <= generator_nxt;
    end
  end

  assign cfg.direction  = direction_r;
  assign cfg.check_kind = check_kind_r;
  assign cfg.generator  = generator_r;

  crcl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_bit  (in_data_bit),
    .in_frame_end (in_frame_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  crcl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty)
  );

  crcl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (head_job),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit         (out_bit),
    .out_is_verdict  (out_is_verdict),
    .out_error_found (out_error_found),
    .out_run_end     (out_run_end)
  );

endmodule

>>> src/crcl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_front: bit acceptance and classification
// Updates the running CRC, parity and receive strip line for each accepted
// bit, and turns the bit into a job for the back part.
// ----------------------------------------------------------------------------
module crcl_front
  import crcl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_data_bit,
  input  logic in_frame_end,
  input  logic q_full,
  output logic q_push,
  output job_t q_job
);

  logic [CHECK_WIDTH-1:0] remainder_r, remainder_nxt;
  logic                   parity_r, parity_nxt;
  logic [CHECK_WIDTH-1:0] delay_r, delay_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;

  logic                   accept;
  logic                   top_bit;
  logic [CHECK_WIDTH-1:0] rem_upd;
  logic                   par_upd;
  logic [FILL_W-1:0]      fill_upd;
  logic                   rx_emit;
  logic                   rx_bit;
  logic                   rx_err;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Running check state update for one bit.
  always_comb begin
    top_bit = remainder_r[CHECK_WIDTH-1];
    par_upd = parity_r ^ in_data_bit;
    if (cfg.direction == DIR_TRANSMIT) begin
      rem_upd = {remainder_r[CHECK_WIDTH-2:0], 1'b0} ^
                ((top_bit ^ in_data_bit) ? cfg.generator : '0);
    end else begin
      rem_upd = {remainder_r[CHECK_WIDTH-2:0], in_data_bit} ^
                (top_bit ? cfg.generator : '0);
    end
    fill_upd = (fill_r < FILL_W'(CHECK_WIDTH)) ? fill_r + FILL_W'(1) : fill_r;
  end

  // Receive strip line: release the oldest bit once the line holds the check.
  always_comb begin
    if (cfg.check_kind == KIND_CRC) begin
      rx_emit = (fill_r >= FILL_W'(CHECK_WIDTH));
      rx_bit  = delay_r[CHECK_WIDTH-1];
      if (fill_upd < FILL_W'(CHECK_WIDTH)) begin
        rx_err = 1'b1;
      end else begin
        rx_err = (rem_upd != '0);
      end
    end else begin
      rx_emit = (fill_r != '0);
      rx_bit  = delay_r[0];
      rx_err  = par_upd;
    end
  end

  // Job built from the accepted bit.
  always_comb begin
    q_job = '0;
    if (cfg.direction == DIR_TRANSMIT) begin
      q_job.has_bit = 1'b1;
      q_job.bit_val = in_data_bit;
      if (in_frame_end) begin
        if (cfg.check_kind == KIND_CRC) begin
          q_job.tail = TAIL_CRC;
          q_job.data = rem_upd;
        end else begin
          q_job.tail = TAIL_PARITY;
          q_job.data = CHECK_WIDTH'(par_upd);
        end
      end else begin
        q_job.tail = TAIL_NONE;
      end
    end else begin
      q_job.has_bit = rx_emit;
      q_job.bit_val = rx_bit;
      if (in_frame_end) begin
        q_job.tail = TAIL_VERDICT;
        q_job.data = CHECK_WIDTH'(rx_err);
      end else begin
        q_job.tail = TAIL_NONE;
      end
    end
    q_push = accept && (q_job.has_bit || (q_job.tail != TAIL_NONE));
  end

  // Next state: update on a transfer, clear at the end of a frame.
  always_comb begin
    remainder_nxt = remainder_r;
    parity_nxt    = parity_r;
    delay_nxt     = delay_r;
    fill_nxt      = fill_r;
    if (accept) begin
      if (in_frame_end) begin
        remainder_nxt = '0;
        parity_nxt    = 1'b0;
        delay_nxt     = '0;
        fill_nxt      = '0;
      end else begin
        remainder_nxt = rem_upd;
        parity_nxt    = par_upd;
        if (cfg.direction == DIR_RECEIVE) begin
          delay_nxt = {delay_r[CHECK_WIDTH-2:0], in_data_bit};
          fill_nxt  = fill_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remainder_r <= '0;
      parity_r    <= 1'b0;
      delay_r     <= '0;
      fill_r      <= '0;
    end else begin
      remainder_r <= remainder_nxt;
      parity_r    <= parity_nxt;
      delay_r     <= delay_nxt;
      fill_r      <= fill_nxt;
    end
  end

endmodule

>>> src/crcl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_queue: job queue between front and back
// A small first-in first-out buffer of jobs so that each side stalls on its own.
// ----------------------------------------------------------------------------
module crcl_queue
  import crcl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> src/crcl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcl_back: result serializer
// Walks through the job at the head of the queue and places one result item
// per cycle into the output register whenever that register is free.
// ----------------------------------------------------------------------------
module crcl_back
  import crcl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  job_t q_head,
  input  logic q_empty,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic out_bit,
  output logic out_is_verdict,
  output logic out_error_found,
  output logic out_run_end
);

  logic             out_valid_r, out_valid_nxt;
  logic             bit_r, verdict_r, error_r, run_end_r;
  logic             bit_sent_r, bit_sent_nxt;
  logic [IDX_W-1:0] tail_idx_r, tail_idx_nxt;

  logic             out_free;
  logic             load;
  logic             is_bit_item;
  logic             job_done;
  logic [IDX_W-1:0] rev_idx;
  logic             item_bit, item_verdict, item_error, item_run_end;

  assign out_free = !out_valid_r || out_ready;
  assign load     = !q_empty && out_free;
  assign q_pop    = load && job_done;
  assign rev_idx  = IDX_W'(CHECK_WIDTH - 1) - tail_idx_r;

  // Current result item of the head job.
  always_comb begin
    is_bit_item  = q_head.has_bit && !bit_sent_r;
    item_bit     = 1'b0;
    item_verdict = 1'b0;
    item_error   = 1'b0;
    item_run_end = 1'b0;
    job_done     = 1'b1;
    if (is_bit_item) begin
      item_bit = q_head.bit_val;
      job_done = (q_head.tail == TAIL_NONE);
    end else begin
      case (q_head.tail)
        TAIL_PARITY: begin
          item_bit     = q_head.data[0];
          item_run_end = 1'b1;
        end
        TAIL_CRC: begin
          item_bit     = q_head.data[rev_idx];
          item_run_end = (tail_idx_r == IDX_W'(CHECK_WIDTH - 1));
          job_done     = item_run_end;
        end
        TAIL_VERDICT: begin
          item_verdict = 1'b1;
          item_error   = q_head.data[0];
          item_run_end = 1'b1;
        end
        default: begin
          job_done = 1'b1;
        end
      endcase
    end
  end

  // Position within the head job.
  always_comb begin
    bit_sent_nxt = bit_sent_r;
    tail_idx_nxt = tail_idx_r;
    if (load) begin
      if (job_done) begin
        bit_sent_nxt = 1'b0;
        tail_idx_nxt = '0;
      end else if (is_bit_item) begin
        bit_sent_nxt = 1'b1;
      end else begin
        tail_idx_nxt = tail_idx_r + IDX_W'(1);
      end
    end
  end

  // Output register valid.
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bit_sent_r  <= 1'b0;
      tail_idx_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      bit_sent_r  <= bit_sent_nxt;
      tail_idx_r  <= tail_idx_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      bit_r     <= item_bit;
      verdict_r <= item_verdict;
      error_r   <= item_error;
      run_end_r <= item_run_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit         = bit_r;
  assign out_is_verdict  = verdict_r;
  assign out_error_found = error_r;
  assign out_run_end     = run_end_r;

endmodule
